// File: rtl/core/imu_sd_pkg.sv
// imu_sd_pkg: shared types and constants of the IMU stillness detector.
// No dependencies; imported by every module under rtl/core.
package imu_sd_pkg;

    localparam int STILL_W     = 16;  // still counter and target width
    localparam int LIMIT_W     = 34;  // squared range limit width
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 34;
    localparam int OUT_DATA_W  = 24;  // moving, still_count, done_res, padded to bytes

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_ACC_LIMIT_SQ  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_LIMIT_SQ = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STILL_TARGET  = 2'd2;

    // reset values: 100^2 and round((0.03 * 8192)^2)
    localparam logic [LIMIT_W-1:0] ACC_LIMIT_SQ_RST  = 34'd10000;
    localparam logic [LIMIT_W-1:0] GYRO_LIMIT_SQ_RST = 34'd60398;
    localparam logic [STILL_W-1:0] STILL_TARGET_RST  = 16'd100;

    // commit control from the top level to each extremes tracker
    typedef struct packed {
        logic load;     // commit this sample's extremes
        logic reload;   // motion: extremes reload from the sample
    } trk_ctrl_t;

endpackage

// File: rtl/core/imu_stillness_detector_unit.sv
// imu_stillness_detector_unit: top level of the IMU stillness detector.
// Depends on imu_sd_pkg, imu_sd_tracker and imu_sd_range_sq.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | restart, acc_x..z, rate_x..z (one sample)
//  m_      | out | m_tvalid / m_tready  | moving, still_count, done_res
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (limit/target regs)
//
// Rate: one request per clock while m_tready is high; an s_ handshake passes
//   the input register, then the result register, before reaching m_.
// The extremes/compare/counter update is combinational logic: track, subtract,
//   three squares per sensor, add and compare, then select.
// Reset: aresetn clears extremes, counter, valid flags; config gets reset values.
// Stalls: with m_tready low the result holds and one more request is held in
//   the input register; s_tready then drops. cfg_ready is always high.
module imu_stillness_detector_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // sample request
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] restart, then acc_x, acc_y, acc_z, rate_x, rate_y, rate_z
    // at SAMPLE_WIDTH bits each, zero padding above
    input  logic [((1+6*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    // result request
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [0] moving, [16:1] still_count, [17] done_res, zero padding above
    output logic [imu_sd_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [imu_sd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [imu_sd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import imu_sd_pkg::*;

    localparam int W      = SAMPLE_WIDTH;
    localparam int IN_W   = 1 + 6*W;
    localparam int SQ_W   = 2*W + 4;
    localparam int CMP_W  = (SQ_W > LIMIT_W) ? SQ_W : LIMIT_W;

    // ---------------- configuration registers ----------------
    logic [LIMIT_W-1:0] acc_limit_reg;
    logic [LIMIT_W-1:0] gyro_limit_reg;
    logic [STILL_W-1:0] target_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_limit_reg  <= ACC_LIMIT_SQ_RST;
            gyro_limit_reg <= GYRO_LIMIT_SQ_RST;
            target_reg     <= STILL_TARGET_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ACC_LIMIT_SQ:  acc_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_GYRO_LIMIT_SQ: gyro_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_STILL_TARGET:  target_reg     <= cfg_data[STILL_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic            in_valid_reg;
    logic            in_valid_next;
    logic [IN_W-1:0] in_data_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            advance;   // input register item moves into the result register
    logic            in_load;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_load | (in_valid_reg & ~advance);
        out_valid_next = advance | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
    end

    logic           in_restart;
    logic [3*W-1:0] acc_sample;
    logic [3*W-1:0] rate_sample;

    assign in_restart  = in_data_reg[0];
    assign acc_sample  = in_data_reg[1 +: 3*W];
    assign rate_sample = in_data_reg[1+3*W +: 3*W];

    // ---------------- extremes and range check ----------------
    trk_ctrl_t      trk_ctrl;
    logic [3*W-1:0] acc_hi;
    logic [3*W-1:0] acc_lo;
    logic [3*W-1:0] rate_hi;
    logic [3*W-1:0] rate_lo;
    logic [SQ_W-1:0] acc_len_sq;
    logic [SQ_W-1:0] rate_len_sq;
    logic            moving;

    imu_sd_tracker #(.W(W)) u_acc_trk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (trk_ctrl),
        .restart (in_restart),
        .sample  (acc_sample),
        .hi_cur  (acc_hi),
        .lo_cur  (acc_lo)
    );

    imu_sd_tracker #(.W(W)) u_rate_trk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (trk_ctrl),
        .restart (in_restart),
        .sample  (rate_sample),
        .hi_cur  (rate_hi),
        .lo_cur  (rate_lo)
    );

    imu_sd_range_sq #(.W(W)) u_acc_rng (
        .hi     (acc_hi),
        .lo     (acc_lo),
        .len_sq (acc_len_sq)
    );

    imu_sd_range_sq #(.W(W)) u_rate_rng (
        .hi     (rate_hi),
        .lo     (rate_lo),
        .len_sq (rate_len_sq)
    );

    // equal to the limit still counts as still
    assign moving = (CMP_W'(acc_len_sq)  > CMP_W'(acc_limit_reg)) ||
                    (CMP_W'(rate_len_sq) > CMP_W'(gyro_limit_reg));

    assign trk_ctrl = '{load: advance, reload: moving};

    // ---------------- still counter ----------------
    logic [STILL_W-1:0] counter_reg;
    logic [STILL_W-1:0] counter_next;
    logic [STILL_W:0]   cnt_inc;
    logic [STILL_W-1:0] cnt_sat;
    logic               done_now;

    always_comb begin
        cnt_inc = {1'b0, (in_restart ? {STILL_W{1'b0}} : counter_reg)} + 1'b1;
        // saturate at target; also pulls a counter down after target is lowered
        cnt_sat = (cnt_inc > {1'b0, target_reg}) ? target_reg : cnt_inc[STILL_W-1:0];
        if (moving) begin
            counter_next = '0;
            done_now     = 1'b0;
        end else begin
            counter_next = cnt_sat;
            done_now     = cnt_sat >= target_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
        end else if (advance) begin
            counter_reg <= counter_next;
        end
    end

    // ---------------- result register ----------------
    logic               moving_reg;
    logic [STILL_W-1:0] count_reg;
    logic               done_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            moving_reg <= moving;
            count_reg  <= counter_next;
            done_reg   <= done_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W-STILL_W-2)'(0), done_reg, count_reg, moving_reg};

    // ---------------- assertions ----------------
    // a motion result always carries a cleared count and no done
    a_moving_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && moving_reg |-> count_reg == '0 && !done_reg)
        else $error("motion result with nonzero count or done");

    // backpressure at the input only when both registers are occupied
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("s_tready low without a full pipeline");

    // motion clears the still counter on the next clock
    a_motion_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && moving |=> counter_reg == '0)
        else $error("still counter not cleared after motion");

    // result register loads exactly when an item leaves the input register
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result missing after advance");

endmodule

// File: rtl/core/imu_sd_tracker.sv
// imu_sd_tracker: per-axis running max/min registers for one 3-axis sensor.
// Depends on imu_sd_pkg (trk_ctrl_t).
module imu_sd_tracker #(
    parameter int W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  imu_sd_pkg::trk_ctrl_t ctrl,
    input  logic                  restart,  // clear extremes before the sample applies
    input  logic [3*W-1:0]        sample,
    output logic [3*W-1:0]        hi_cur,
    output logic [3*W-1:0]        lo_cur
);
    import imu_sd_pkg::*;

    logic [3*W-1:0] hi_reg;
    logic [3*W-1:0] lo_reg;
    logic [3*W-1:0] hi_next;
    logic [3*W-1:0] lo_next;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [W-1:0] x;
        logic signed [W-1:0] base_hi;
        logic signed [W-1:0] base_lo;
        logic signed [W-1:0] hi_ax;
        logic signed [W-1:0] lo_ax;

        assign x       = $signed(sample[a*W +: W]);
        assign base_hi = restart ? '0 : $signed(hi_reg[a*W +: W]);
        assign base_lo = restart ? '0 : $signed(lo_reg[a*W +: W]);

        // min only moves when max did not
        always_comb begin
            hi_ax = base_hi;
            lo_ax = base_lo;
            if (x > base_hi) begin
                hi_ax = x;
            end else if (x < base_lo) begin
                lo_ax = x;
            end
        end

        assign hi_cur[a*W +: W] = hi_ax;
        assign lo_cur[a*W +: W] = lo_ax;
    end

    always_comb begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctrl.load) begin
            hi_next = ctrl.reload ? sample : hi_cur;
            lo_next = ctrl.reload ? sample : lo_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

endmodule

// File: rtl/core/imu_sd_range_sq.sv
// imu_sd_range_sq: squared length of a 3-axis range vector (max - min).
// Depends on imu_sd_pkg only for the house import convention.
module imu_sd_range_sq #(
    parameter int W = 16
) (
    input  logic [3*W-1:0] hi,
    input  logic [3*W-1:0] lo,
    output logic [2*W+3:0] len_sq
);
    import imu_sd_pkg::*;

    logic [2*W+1:0] sq [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [W:0] diff;
        logic        [W:0] mag;

        assign diff = $signed({hi[a*W+W-1], hi[a*W +: W]})
                    - $signed({lo[a*W+W-1], lo[a*W +: W]});
        assign mag  = diff[W] ? (W+1)'(0) - diff : diff;
        assign sq[a] = mag * mag;
    end

    assign len_sq = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

endmodule
